// ===== sv/pt100_pkg.sv =====
// Shared constants, breakpoint tables and job type for the Pt100 converter.
package pt100_pkg;

   localparam int TABLE_POINTS = 36;
   localparam int IDX_W        = 6;
   localparam int RES_W        = 16;
   localparam int TEMP_W       = 16;
   localparam int SPAN_W       = 11;   // widest resistance step is 2000
   localparam int DT_W         = 13;   // widest temperature step is 5000
   localparam int PROD_W       = SPAN_W + DT_W;
   localparam int QUOT_W       = DT_W;
   localparam int CNT_W        = 5;

   localparam logic [IDX_W-1:0] FIRST_IDX = '0;
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_POINTS - 1);

   localparam logic [1:0] FLAG_IN   = 2'd0;
   localparam logic [1:0] FLAG_LOW  = 2'd1;
   localparam logic [1:0] FLAG_HIGH = 2'd2;

   localparam logic signed [TEMP_W-1:0] TEMP_MIN = -16'sd5000;
   localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sd25000;

   // breakpoint resistances, 0.01 ohm
   localparam logic [RES_W-1:0] RES_TABLE [TABLE_POINTS] = '{
      16'd8031,  16'd8229,  16'd8427,  16'd8625,  16'd8822,  16'd9019,
      16'd9216,  16'd9412,  16'd9609,  16'd9804,  16'd10000, 16'd10195,
      16'd10390, 16'd10585, 16'd10779, 16'd10973, 16'd11167, 16'd11361,
      16'd11554, 16'd11747, 16'd11940, 16'd12132, 16'd12324, 16'd12516,
      16'd12707, 16'd12898, 16'd13089, 16'd13280, 16'd13470, 16'd13660,
      16'd13850, 16'd14039, 16'd14229, 16'd15731, 16'd17584, 16'd19584
   };

   // breakpoint temperatures, 0.01 deg C
   localparam logic signed [TEMP_W-1:0] TEMP_TABLE [TABLE_POINTS] = '{
      -16'sd5000, -16'sd4500, -16'sd4000, -16'sd3500, -16'sd3000, -16'sd2500,
      -16'sd2000, -16'sd1500, -16'sd1000, -16'sd500,  16'sd0,     16'sd500,
      16'sd1000,  16'sd1500,  16'sd2000,  16'sd2500,  16'sd3000,  16'sd3500,
      16'sd4000,  16'sd4500,  16'sd5000,  16'sd5500,  16'sd6000,  16'sd6500,
      16'sd7000,  16'sd7500,  16'sd8000,  16'sd8500,  16'sd9000,  16'sd9500,
      16'sd10000, 16'sd10500, 16'sd11000, 16'sd15000, 16'sd20000, 16'sd25000
   };

   typedef struct packed {
      logic [1:0]               flag;
      logic signed [TEMP_W-1:0] t0;
      logic [SPAN_W-1:0]        delta;
      logic [DT_W-1:0]          dt;
      logic [SPAN_W-1:0]        span;
   } pt100_job_type;

endpackage

// ===== sv/pt100_front.sv =====
// Front end: accepts a request, classifies it and binary-searches the segment.
module pt100_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [15:0]                req_resistance_centiohm,
   output logic                       push_valid_o,
   input  logic                       full_i,
   output pt100_pkg::pt100_job_type   push_job_o
);
   import pt100_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_PUSH} state_type;

   state_type        state_ff, state_in;
   logic [RES_W-1:0] r_ff, r_in;
   logic [IDX_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [1:0]       flag_ff, flag_in;

   logic [IDX_W:0]   mid_sum;
   logic [IDX_W-1:0] mid;
   logic [IDX_W-1:0] gap;
   logic [RES_W-1:0] res_lo, res_hi, r_diff, span_diff;
   logic signed [TEMP_W-1:0] t_lo, t_hi, dt_diff;

   assign req_stall    = (state_ff != ST_IDLE);
   assign push_valid_o = (state_ff == ST_PUSH);

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[IDX_W:1];
   assign gap     = hi_ff - lo_ff;

   always_comb begin
      state_in = state_ff;
      r_in     = r_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      flag_in  = flag_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               r_in     = req_resistance_centiohm;
               lo_in    = FIRST_IDX;
               hi_in    = LAST_IDX;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // invariant while in range: RES[lo] <= r < RES[hi]
            if (r_ff <= RES_TABLE[FIRST_IDX]) begin
               flag_in  = FLAG_LOW;
               state_in = ST_PUSH;
            end else if (r_ff >= RES_TABLE[LAST_IDX]) begin
               flag_in  = FLAG_HIGH;
               state_in = ST_PUSH;
            end else if (gap == IDX_W'(1)) begin
               flag_in  = FLAG_IN;
               state_in = ST_PUSH;
            end else if (r_ff >= RES_TABLE[mid]) begin
               lo_in = mid;
            end else begin
               hi_in = mid;
            end
         end
         ST_PUSH: begin
            if (!full_i) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      r_ff    <= r_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      flag_ff <= flag_in;
   end

   // segment parameters for the back end
   assign res_lo    = RES_TABLE[lo_ff];
   assign res_hi    = RES_TABLE[hi_ff];
   assign t_lo      = TEMP_TABLE[lo_ff];
   assign t_hi      = TEMP_TABLE[hi_ff];
   assign r_diff    = r_ff - res_lo;
   assign span_diff = res_hi - res_lo;
   assign dt_diff   = t_hi - t_lo;

   always_comb begin
      push_job_o.flag  = flag_ff;
      push_job_o.t0    = t_lo;
      push_job_o.delta = r_diff[SPAN_W-1:0];
      push_job_o.dt    = dt_diff[DT_W-1:0];
      push_job_o.span  = span_diff[SPAN_W-1:0];
      case (flag_ff)
         FLAG_LOW: begin
            push_job_o.t0    = TEMP_MIN;
            push_job_o.delta = '0;
            push_job_o.dt    = '0;
            push_job_o.span  = SPAN_W'(1);
         end
         FLAG_HIGH: begin
            push_job_o.t0    = TEMP_MAX;
            push_job_o.delta = '0;
            push_job_o.dt    = '0;
            push_job_o.span  = SPAN_W'(1);
         end
         default: ;
      endcase
   end

endmodule

// ===== sv/pt100_fifo.sv =====
// Two-entry job queue between the front and back ends.
module pt100_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid_i,
   input  pt100_pkg::pt100_job_type push_job_i,
   output logic                     full_o,
   output logic                     pop_valid_o,
   input  logic                     pop_i,
   output pt100_pkg::pt100_job_type pop_job_o
);
   import pt100_pkg::*;

   pt100_job_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          do_push, do_pop;

   assign full_o      = (count_ff == 2'd2);
   assign pop_valid_o = (count_ff != 2'd0);
   assign pop_job_o   = slot_ff[rd_ptr_ff];
   assign do_push     = push_valid_i && !full_o;
   assign do_pop      = pop_i && pop_valid_o;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job_i;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

// ===== sv/pt100_back.sv =====
// Back end: multiply, bit-serial restoring divide, and the result register.
module pt100_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid_i,
   output logic                     pop_o,
   input  pt100_pkg::pt100_job_type pop_job_i,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [15:0]       rsp_temperature_centideg,
   output logic [1:0]               rsp_range_flag
);
   import pt100_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_OUT} state_type;

   state_type                state_ff, state_in;
   pt100_job_type            job_ff, job_in;
   logic [PROD_W-1:0]        div_ff, div_in;
   logic [SPAN_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     valid_ff, valid_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic [1:0]               flag_ff, flag_in;

   logic [SPAN_W:0]   trial, trial_sub;
   logic              q_bit;
   logic [QUOT_W-1:0] quot;

   assign trial     = {rem_ff, div_ff[PROD_W-1]};
   assign q_bit     = (trial >= {1'b0, job_ff.span});
   assign trial_sub = trial - {1'b0, job_ff.span};
   assign quot      = {div_ff[QUOT_W-2:0], q_bit};

   assign pop_o                    = (state_ff == ST_IDLE) && pop_valid_i;
   assign rsp_valid                = valid_ff;
   assign rsp_temperature_centideg = temp_ff;
   assign rsp_range_flag           = flag_ff;

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      temp_in  = temp_ff;
      flag_in  = flag_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid_i) begin
               job_in = pop_job_i;
               if (pop_job_i.flag == FLAG_IN) begin
                  state_in = ST_MUL;
               end else begin
                  temp_in  = pop_job_i.t0;
                  flag_in  = pop_job_i.flag;
                  valid_in = 1'b1;
                  state_in = ST_OUT;
               end
            end
         end
         ST_MUL: begin
            div_in   = {{DT_W{1'b0}}, job_ff.delta} * {{SPAN_W{1'b0}}, job_ff.dt};
            rem_in   = '0;
            cnt_in   = CNT_W'(PROD_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            div_in = {div_ff[PROD_W-2:0], q_bit};
            rem_in = q_bit ? trial_sub[SPAN_W-1:0] : trial[SPAN_W-1:0];
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               temp_in  = job_ff.t0 + $signed({{(TEMP_W-QUOT_W){1'b0}}, quot});
               flag_in  = FLAG_IN;
               valid_in = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      job_ff  <= job_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      temp_ff <= temp_in;
      flag_ff <= flag_in;
   end

   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < job_ff.span))
      else $error("divider remainder not below divisor");

   a_flag_code: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (flag_ff == FLAG_IN || flag_ff == FLAG_LOW || flag_ff == FLAG_HIGH))
      else $error("bad range flag on result");

   a_valid_out_state: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (state_ff == ST_OUT))
      else $error("result valid outside output state");

endmodule

// ===== sv/pt100_resistance_to_temperature.sv =====
// Pt100 resistance to temperature converter, top level.
//
// Converts one Pt100 resistance request (unsigned, 0.01 ohm) into a temperature
// in 0.01 deg C (two's complement, -5000 .. 25000) plus a range flag: 0 inside
// the table, 1 clamped low (at or below 80.31 ohm gives -50.00), 2 clamped high
// (at or above 195.84 ohm gives 250.00). The curve is a 36-point breakpoint
// table (every 5 deg from -50 to 110, then 150, 200, 250) with linear
// interpolation; the interpolated fraction is truncated. A resistance equal to
// an inner breakpoint yields that breakpoint's temperature exactly.
// The front end takes a request, then runs a binary search over the table, one
// probe per cycle (at most six probes), and hands a job to a two-entry queue;
// it takes no new request until that job is queued. The back end does a
// multiply step and then a restoring divide at one quotient bit per cycle,
// takes no new job until its result is accepted, and so sets the sustained
// rate. Clamped requests skip the divide. The result sits in an output
// register, so the front end keeps taking requests while a result waits on
// rsp_stall, until the queue is full. No configuration, no state kept between
// requests.
module pt100_resistance_to_temperature (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_resistance_centiohm,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_temperature_centideg,
   output logic [1:0]         rsp_range_flag
);
   import pt100_pkg::*;

   // front -> queue
   logic          push_valid;
   logic          q_full;
   pt100_job_type push_job;

   // queue -> back
   logic          pop_valid;
   logic          pop;
   pt100_job_type pop_job;

   pt100_front u_front (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_resistance_centiohm (req_resistance_centiohm),
      .push_valid_o            (push_valid),
      .full_i                  (q_full),
      .push_job_o              (push_job)
   );

   pt100_fifo u_fifo (
      .clock        (clock),
      .reset        (reset),
      .push_valid_i (push_valid),
      .push_job_i   (push_job),
      .full_o       (q_full),
      .pop_valid_o  (pop_valid),
      .pop_i        (pop),
      .pop_job_o    (pop_job)
   );

   pt100_back u_back (
      .clock                    (clock),
      .reset                    (reset),
      .pop_valid_i              (pop_valid),
      .pop_o                    (pop),
      .pop_job_i                (pop_job),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_temperature_centideg (rsp_temperature_centideg),
      .rsp_range_flag           (rsp_range_flag)
   );

endmodule
